FILE: rtl/can_object_value_capture_table_core_macros.svh
// Assertion macros used by the checker of the capture table.
`ifndef CAN_OBJECT_VALUE_CAPTURE_TABLE_CORE_MACROS_SVH
`define CAN_OBJECT_VALUE_CAPTURE_TABLE_CORE_MACROS_SVH

// A property that is checked only while the block is out of reset.
`define COVCT_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("capture table check failed");

// A property that is checked at every clock edge, reset included.
`define COVCT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("capture table check failed");

`endif

FILE: rtl/covct_pkg.sv
package covct_pkg;

  // Command codes of an input request.
  typedef enum logic [1:0] {
    CmdRegister = 2'd0,
    CmdFrame    = 2'd1,
    CmdQuery    = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusFull     = 2'd2
  } status_e;

  // Byte 0 of a frame that selects the alternate value layout.
  localparam logic [7:0] FrameAltTag = 8'h01;

  typedef struct packed {
    logic [1:0]  command;
    logic [10:0] can_id;
    logic [15:0] obj_index;
    logic [7:0]  obj_subindex;
    logic [63:0] frame_data;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        value;
    logic signed [15:0] short_value;
  } out_rsp_t;

endpackage

FILE: rtl/can_object_value_capture_table_core.sv
// CAN object value capture table. The block keeps up to TABLE_ENTRIES watched
// keys (CAN identifier, object index, subindex) with the last 32-bit value seen
// for each. A register request appends a key with value zero, or reports table
// full. A frame request decodes index, subindex and value from the frame bytes
// and writes the value into every entry whose key matches. A query request
// returns the value of the matching entry in the highest occupied slot, or
// reports not found. Every request gives exactly one result. Requests are
// taken into an input register; while a request sits there, all entries are
// compared in parallel, and when it moves on the table is updated and the
// result is written to the output register. The block sustains one request
// per clock cycle while the output side does not stall. A result is offered
// from the output register once its request has moved on from the input
// register. While a stalled result waits in the output register, the input
// register can still take one more request; after that the input stalls
// until the result is taken.
module can_object_value_capture_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  covct_pkg::in_req_t   in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output covct_pkg::out_rsp_t  out_rsp_o
);

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_ENTRIES);

  // Input register.
  logic               in_valid_q;
  covct_pkg::in_req_t in_q;

  // Output register.
  logic                out_valid_q;
  covct_pkg::out_rsp_t out_q;
  covct_pkg::out_rsp_t out_d;

  // Table storage. Only the valid bits and the fill count are reset; the key
  // and value fields are written when a slot becomes valid.
  logic [TABLE_ENTRIES-1:0] ent_valid_q;
  logic [10:0]              ent_id_q    [TABLE_ENTRIES];
  logic [15:0]              ent_index_q [TABLE_ENTRIES];
  logic [7:0]               ent_sub_q   [TABLE_ENTRIES];
  logic [31:0]              ent_value_q [TABLE_ENTRIES];
  logic [CntW-1:0]          ent_count_q;

  logic                     advance;
  logic                     in_accept;
  logic [15:0]              key_index;
  logic [7:0]               key_sub;
  logic [31:0]              frame_value;
  logic [TABLE_ENTRIES-1:0] match;
  logic                     is_register;
  logic                     is_frame;
  logic                     table_full;
  logic                     found;
  logic [31:0]              found_value;

  // The input register moves on whenever the output register is empty or is
  // being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
  end

  assign is_register = (in_q.command == covct_pkg::CmdRegister);
  assign is_frame    = (in_q.command == covct_pkg::CmdFrame);
  assign table_full  = (ent_count_q == CntFull);

  // Frame decode. Normally the frame carries index, subindex and value
  // directly. With the alternate tag in byte 0, index and subindex are zero
  // and the value is assembled from bytes 3, 2, 5 and 4.
  always_comb begin
    frame_value = in_q.frame_data[63:32];
    key_index   = in_q.obj_index;
    key_sub     = in_q.obj_subindex;
    if (is_frame) begin
      if (in_q.frame_data[7:0] != covct_pkg::FrameAltTag) begin
        key_index = in_q.frame_data[23:8];
        key_sub   = in_q.frame_data[31:24];
      end else begin
        key_index   = 16'h0000;
        key_sub     = 8'h00;
        frame_value = {in_q.frame_data[31:24], in_q.frame_data[23:16],
                       in_q.frame_data[47:40], in_q.frame_data[39:32]};
      end
    end
  end

  // Parallel key compare across all slots.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = ent_valid_q[i] && (ent_id_q[i] == in_q.can_id) &&
                 (ent_index_q[i] == key_index) && (ent_sub_q[i] == key_sub);
    end
  end

  // Query picks the highest matching slot: later slots override earlier ones.
  always_comb begin
    found       = 1'b0;
    found_value = 32'h0000_0000;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match[i]) begin
        found       = 1'b1;
        found_value = ent_value_q[i];
      end
    end
  end

  // Result of the request in the input register.
  always_comb begin
    out_d.status      = covct_pkg::StatusOk;
    out_d.value       = 32'h0000_0000;
    out_d.short_value = 16'sh0000;
    unique case (in_q.command)
      covct_pkg::CmdRegister: begin
        if (table_full) begin
          out_d.status = covct_pkg::StatusFull;
        end
      end
      covct_pkg::CmdFrame: begin
        out_d.status = covct_pkg::StatusOk;
      end
      covct_pkg::CmdQuery: begin
        if (found) begin
          out_d.value       = found_value;
          out_d.short_value = signed'(found_value[15:0]);
        end else begin
          out_d.status = covct_pkg::StatusNotFound;
        end
      end
      default: begin
        out_d.status = covct_pkg::StatusOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Table control state: valid bits and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      ent_count_q <= '0;
    end else if (advance && is_register && !table_full) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (CntW'(i) == ent_count_q) begin
          ent_valid_q[i] <= 1'b1;
        end
      end
      ent_count_q <= ent_count_q + 1'b1;
    end
  end

  // Table keys and values. A new key starts with value zero; a frame writes
  // every matching slot.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (advance && is_register && !table_full && (CntW'(i) == ent_count_q)) begin
        ent_id_q[i]    <= in_q.can_id;
        ent_index_q[i] <= in_q.obj_index;
        ent_sub_q[i]   <= in_q.obj_subindex;
        ent_value_q[i] <= 32'h0000_0000;
      end else if (advance && is_frame && match[i]) begin
        ent_value_q[i] <= frame_value;
      end
    end
  end

endmodule

FILE: rtl/covct_checker.sv
`include "can_object_value_capture_table_core_macros.svh"

module covct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input covct_pkg::out_rsp_t out_rsp_o
);

  // A result that is not ok never carries a value.
  `COVCT_ASSERT_RST(a_fail_zero_value, clk_i, rst_ni, out_valid_o && (out_rsp_o.status != covct_pkg::StatusOk) |-> (out_rsp_o.value == 32'h0000_0000) && (out_rsp_o.short_value == 16'sh0000))

  // The short value is always the low half of the full value.
  `COVCT_ASSERT_ALWAYS(a_short_value, clk_i, out_valid_o |-> (out_rsp_o.short_value == signed'(out_rsp_o.value[15:0])))

  // A stalled result stays offered.
  `COVCT_ASSERT_RST(a_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // A stalled result does not change.
  `COVCT_ASSERT_RST(a_rsp_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_rsp_o))

endmodule

bind can_object_value_capture_table_core covct_checker u_covct_checker (.*);

FILE: sim/covct_capture_checker.sv
`timescale 1ns / 100ps

module covct_capture_checker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  covct_pkg::in_req_t  in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  covct_pkg::out_rsp_t out_rsp_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Shadow copy of the capture table.
  bit          slot_used  [TABLE_ENTRIES];
  logic [10:0] slot_id    [TABLE_ENTRIES];
  logic [15:0] slot_index [TABLE_ENTRIES];
  logic [7:0]  slot_sub   [TABLE_ENTRIES];
  logic [31:0] slot_value [TABLE_ENTRIES];
  int          slot_count;

  covct_pkg::out_rsp_t expected_results[$];

  function automatic bit slot_hit(int s, logic [10:0] id, logic [15:0] idx, logic [7:0] sub);
    return slot_used[s] && slot_id[s] == id && slot_index[s] == idx && slot_sub[s] == sub;
  endfunction

  // Applies one request to the shadow table and returns the result it must give.
  function automatic covct_pkg::out_rsp_t apply_request(covct_pkg::in_req_t r);
    covct_pkg::out_rsp_t rsp;
    logic [15:0]         fidx;
    logic [7:0]          fsub;
    logic [31:0]         fval;
    bit                  hit;
    rsp = '0;
    case (r.command)
      covct_pkg::CmdRegister: begin
        if (slot_count < TABLE_ENTRIES) begin
          slot_used[slot_count]  = 1'b1;
          slot_id[slot_count]    = r.can_id;
          slot_index[slot_count] = r.obj_index;
          slot_sub[slot_count]   = r.obj_subindex;
          slot_value[slot_count] = '0;
          slot_count++;
        end else begin
          rsp.status = covct_pkg::StatusFull;
        end
      end
      covct_pkg::CmdFrame: begin
        if (r.frame_data[7:0] != covct_pkg::FrameAltTag) begin
          fidx = r.frame_data[23:8];
          fsub = r.frame_data[31:24];
          fval = r.frame_data[63:32];
        end else begin
          fidx = '0;
          fsub = '0;
          fval = {r.frame_data[31:24], r.frame_data[23:16],
                  r.frame_data[47:40], r.frame_data[39:32]};
        end
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
          if (slot_hit(s, r.can_id, fidx, fsub)) slot_value[s] = fval;
        end
      end
      covct_pkg::CmdQuery: begin
        hit = 1'b0;
        for (int s = TABLE_ENTRIES - 1; s >= 0; s--) begin
          if (!hit && slot_hit(s, r.can_id, r.obj_index, r.obj_subindex)) begin
            hit = 1'b1;
            rsp.value = slot_value[s];
          end
        end
        if (!hit) rsp.status = covct_pkg::StatusNotFound;
      end
      default: ;
    endcase
    rsp.short_value = rsp.value[15:0];
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    covct_pkg::out_rsp_t want;
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_ENTRIES; s++) slot_used[s] = 1'b0;
      slot_count = 0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_results.push_back(apply_request(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual status %0d value %h",
                   $time, out_rsp_i.status, out_rsp_i.value);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_rsp_i.status !== want.status) begin
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_rsp_i.status);
            fail_count_o++;
          end
          if (out_rsp_i.value !== want.value) begin
            $display("%0t ns: value mismatch, expected %h, actual %h",
                     $time, want.value, out_rsp_i.value);
            fail_count_o++;
          end
          if (out_rsp_i.short_value !== want.short_value) begin
            $display("%0t ns: short_value mismatch, expected %0d, actual %0d",
                     $time, want.short_value, out_rsp_i.short_value);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: sim/can_object_value_capture_table_core_tb.sv
`timescale 1ns / 100ps

module can_object_value_capture_table_core_tb;

  localparam int TableEntries = 16;
  // Start value of the long receiver hold-off countdown, in clock cycles.
  localparam int HoldCycles   = 300;

  // A watched key: CAN identifier, object index and subindex.
  typedef struct packed {
    logic [10:0] id;
    logic [15:0] idx;
    logic [7:0]  sub;
  } obj_key_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  covct_pkg::in_req_t  in_req    = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  covct_pkg::out_rsp_t out_rsp;

  // Idle and stall rates of the current phase, in percent.
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  // Each toggle asks the receiver process for one long hold-off.
  logic hold_toggle    = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;

  int fail_count;
  int pending;

  // Keys that have been registered (including dropped ones, up to twice the table
  // size), used to aim frames and queries at entries that may sit in the table.
  obj_key_t known_keys[$];

  can_object_value_capture_table_core #(
    .TABLE_ENTRIES(TableEntries)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  covct_capture_checker #(
    .TABLE_ENTRIES(TableEntries)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Safety net in case the block hangs: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side. A requested hold-off keeps the stall high until the HoldCycles
  // countdown has run out; otherwise the stall is drawn at the rate of the current phase.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic obj_key_t pick_key();
    return known_keys[$urandom_range(known_keys.size() - 1)];
  endfunction

  // A fresh key. It often shares the identifier of a known key so that keys
  // differing only in index or subindex are exercised, and index and subindex
  // are often zero so that frames with the alternate layout can hit.
  function automatic obj_key_t random_key();
    obj_key_t k;
    k.id  = 11'($urandom);
    k.idx = 16'($urandom);
    k.sub = 8'($urandom);
    if (known_keys.size() != 0 && $urandom_range(1) == 1) k.id = pick_key().id;
    if ($urandom_range(3) == 0) begin
      k.idx = '0;
      k.sub = '0;
    end
    return k;
  endfunction

  // Frame bytes that carry value v for key k. Byte 0 is the layout tag: the
  // alternate tag packs the value as bytes 3, 2, 5, 4 and implies index and
  // subindex zero; any other tag carries index, subindex and value directly.
  // Bytes not used by the layout are random.
  function automatic logic [63:0] frame_bytes(obj_key_t k, logic [31:0] v, logic [7:0] tag);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[7:0] = tag;
    if (tag == covct_pkg::FrameAltTag) begin
      d[31:16] = v[31:16];
      d[47:32] = v[15:0];
    end else begin
      d[23:8]  = k.idx;
      d[31:24] = k.sub;
      d[63:32] = v;
    end
    return d;
  endfunction

  function automatic covct_pkg::in_req_t make_req(covct_pkg::cmd_e cmd, obj_key_t k,
                                                  logic [63:0] d);
    covct_pkg::in_req_t r;
    r.command      = cmd;
    r.can_id       = k.id;
    r.obj_index    = k.idx;
    r.obj_subindex = k.sub;
    r.frame_data   = d;
    return r;
  endfunction

  // Offers one request after a random idle gap and returns at the clock edge
  // where it is accepted. Valid stays high into the next request when no gap
  // is drawn, so it is never dropped and raised in the same time step.
  task automatic send_req(input covct_pkg::in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result has come back. The
  // count is sampled at the falling edge, away from the checker's update.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Random traffic. Most requests are well formed and aimed at known keys;
  // registers are kept rare so the table fills slowly and full is reached
  // partway through. A small share is pure noise over all fields.
  task automatic run_phase(input int n_items, input bit with_hold);
    int                 roll;
    obj_key_t           k;
    logic [7:0]         tag;
    covct_pkg::in_req_t r;
    for (int i = 0; i < n_items; i++) begin
      // Long receiver hold-off while the sender keeps offering, so both the
      // input register and the output register fill and the input stalls.
      if (with_hold && i == n_items / 4) hold_toggle <= ~hold_toggle;
      roll = $urandom_range(99);
      if (roll < 5) begin
        // Register, sometimes as an exact duplicate of a known key.
        k = ($urandom_range(4) == 0) ? pick_key() : random_key();
        r = make_req(covct_pkg::CmdRegister, k, {$urandom, $urandom});
        if (known_keys.size() < 2 * TableEntries) known_keys.push_back(k);
      end else if (roll < 55) begin
        if ($urandom_range(9) < 7) begin
          // Frame aimed at a known key, in either layout where it can match.
          k = pick_key();
          if (k.idx == '0 && k.sub == '0 && $urandom_range(1) == 1) begin
            tag = covct_pkg::FrameAltTag;
          end else begin
            do tag = 8'($urandom_range(255)); while (tag == covct_pkg::FrameAltTag);
          end
          r = make_req(covct_pkg::CmdFrame, k, frame_bytes(k, $urandom, tag));
        end else begin
          r = make_req(covct_pkg::CmdFrame, random_key(), {$urandom, $urandom});
        end
      end else if (roll < 95) begin
        // Query, mostly for a known key, otherwise a likely miss.
        k = ($urandom_range(3) != 0) ? pick_key() : random_key();
        r = make_req(covct_pkg::CmdQuery, k, {$urandom, $urandom});
      end else begin
        r.command      = 2'($urandom_range(3));
        r.can_id       = 11'($urandom);
        r.obj_index    = 16'($urandom);
        r.obj_subindex = 8'($urandom);
        r.frame_data   = {$urandom, $urandom};
      end
      send_req(r);
    end
  endtask

  initial begin
    int       idle_pct [5] = '{0, 82, 0, 11, 0};
    int       stall_pct[5] = '{0, 0, 82, 11, 0};
    obj_key_t k_zero = '0;
    obj_key_t k_max  = '{11'h7FF, 16'hFFFF, 8'hFF};
    obj_key_t k_mid  = '{11'h123, 16'h1000, 8'h01};
    obj_key_t k_miss = '{11'h123, 16'h1000, 8'h02};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty table first: the query misses and the frame
    // matches nothing.
    send_req(make_req(covct_pkg::CmdQuery, k_zero, '0));
    send_req(make_req(covct_pkg::CmdFrame, k_max, frame_bytes(k_max, 32'hDEADBEEF, 8'hFF)));
    // Register keys at both extremes and one in between.
    send_req(make_req(covct_pkg::CmdRegister, k_zero, '0));
    send_req(make_req(covct_pkg::CmdRegister, k_max, '1));
    send_req(make_req(covct_pkg::CmdRegister, k_mid, '0));
    known_keys.push_back(k_zero);
    known_keys.push_back(k_max);
    known_keys.push_back(k_mid);
    // A fresh entry reads back zero; all-ones frame data updates the top key.
    send_req(make_req(covct_pkg::CmdQuery, k_max, '0));
    send_req(make_req(covct_pkg::CmdFrame, k_max, '1));
    send_req(make_req(covct_pkg::CmdQuery, k_max, '0));
    // Alternate layout with a negative low half, then the normal layout with
    // a zero tag byte and the most negative short value.
    send_req(make_req(covct_pkg::CmdFrame, k_zero,
                      frame_bytes(k_zero, 32'h12348765, covct_pkg::FrameAltTag)));
    send_req(make_req(covct_pkg::CmdQuery, k_zero, '0));
    send_req(make_req(covct_pkg::CmdFrame, k_zero, frame_bytes(k_zero, 32'h00008000, 8'h00)));
    send_req(make_req(covct_pkg::CmdQuery, k_zero, '0));
    // Duplicate key: the newer slot wins a query, and a frame updates both.
    send_req(make_req(covct_pkg::CmdFrame, k_mid, frame_bytes(k_mid, 32'h00000055, 8'h02)));
    send_req(make_req(covct_pkg::CmdRegister, k_mid, '0));
    known_keys.push_back(k_mid);
    send_req(make_req(covct_pkg::CmdQuery, k_mid, '0));
    send_req(make_req(covct_pkg::CmdFrame, k_mid, frame_bytes(k_mid, 32'h00007FFF, 8'h80)));
    send_req(make_req(covct_pkg::CmdQuery, k_mid, '0));
    // The alternate tag forces index zero, so this frame misses the key.
    send_req(make_req(covct_pkg::CmdFrame, k_mid,
                      frame_bytes(k_mid, 32'h00000001, covct_pkg::FrameAltTag)));
    send_req(make_req(covct_pkg::CmdQuery, k_mid, '0));
    // Same identifier and index but another subindex is not found.
    send_req(make_req(covct_pkg::CmdQuery, k_miss, '0));
    // All-zero frame data clears the zero key.
    send_req(make_req(covct_pkg::CmdFrame, k_zero, '0));
    send_req(make_req(covct_pkg::CmdQuery, k_zero, '0));
    wait_drained();

    // Random phases with their own idle and stall rates; the sender pauses
    // for a full drain after each one.
    for (int p = 0; p < 5; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct <= stall_pct[p];
      run_phase(260, p == 0);
      wait_drained();
    end

    // Let a few more cycles pass so that any stray result would show up.
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
